[rtl/core/look_at_view_matrix_top_macros.svh]
// Assertion macros for the look-at view matrix block.
`ifndef LOOK_AT_VIEW_MATRIX_TOP_MACROS_SVH
`define LOOK_AT_VIEW_MATRIX_TOP_MACROS_SVH

// Condition implies consequence in the same cycle.
`define LAV_ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lav: assertion failed");

// Expression holds in every cycle out of reset.
`define LAV_ASSERT_ALWAYS(name, expr) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("lav: assertion failed");

`endif

[rtl/core/lav_pkg.sv]
// Shared constants for the look-at view matrix block.
package lav_pkg;
    localparam int FRAC_BITS_DEF = 16;
    localparam int WORD_W        = 32;
    localparam int AXIS_W        = 18;
    localparam int VEC_W         = 58;
    localparam int MAG_W         = 30;
    localparam int ROOT_W        = 31;
    localparam int SUM_W         = 2 * ROOT_W;
    localparam logic signed [WORD_W-1:0] AXIS_MAX = 32'sd131071;
    localparam logic signed [WORD_W-1:0] AXIS_MIN = -32'sd131071;
endpackage

[rtl/core/look_at_view_matrix_top.sv]
// Look-at view matrix: rotation rows and translation from eye, target and up.
//
// Use: drive the nine Q16.16 inputs and raise start for one cycle per item.
// busy is always low, so an item is taken at every edge where start is high;
// items may follow each other in consecutive cycles.
// Each item yields one result: side, upright and back rows (18 bits) and the
// saturated translation shift_x/y/z (32 bits), shown for one cycle with done.
// Throughput is one item per cycle. Each of the three normalizers takes
// FRAC_BITS + 44 stages, set by its 31-stage square root and its
// FRAC_BITS + 1 stage divider; the two cross products take two stages each,
// the translation three.
// Reset clears every valid bit in the pipeline; items in flight are dropped.
// The receiver cannot stall: results leave on the cycle they are shown.
`include "look_at_view_matrix_top_macros.svh"

module look_at_view_matrix_top #(
    parameter int FRAC_BITS = lav_pkg::FRAC_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    output logic                              done,
    input  logic signed [lav_pkg::WORD_W-1:0] eye_x,
    input  logic signed [lav_pkg::WORD_W-1:0] eye_y,
    input  logic signed [lav_pkg::WORD_W-1:0] eye_z,
    input  logic signed [lav_pkg::WORD_W-1:0] target_x,
    input  logic signed [lav_pkg::WORD_W-1:0] target_y,
    input  logic signed [lav_pkg::WORD_W-1:0] target_z,
    input  logic signed [lav_pkg::WORD_W-1:0] up_x,
    input  logic signed [lav_pkg::WORD_W-1:0] up_y,
    input  logic signed [lav_pkg::WORD_W-1:0] up_z,
    output logic signed [lav_pkg::AXIS_W-1:0] side_x,
    output logic signed [lav_pkg::AXIS_W-1:0] side_y,
    output logic signed [lav_pkg::AXIS_W-1:0] side_z,
    output logic signed [lav_pkg::AXIS_W-1:0] upright_x,
    output logic signed [lav_pkg::AXIS_W-1:0] upright_y,
    output logic signed [lav_pkg::AXIS_W-1:0] upright_z,
    output logic signed [lav_pkg::AXIS_W-1:0] back_x,
    output logic signed [lav_pkg::AXIS_W-1:0] back_y,
    output logic signed [lav_pkg::AXIS_W-1:0] back_z,
    output logic signed [lav_pkg::WORD_W-1:0] shift_x,
    output logic signed [lav_pkg::WORD_W-1:0] shift_y,
    output logic signed [lav_pkg::WORD_W-1:0] shift_z
);
    import lav_pkg::*;

    localparam int AW = FRAC_BITS + 2;
    localparam int PW = WORD_W + AW;
    localparam int TW = PW + 3;
    localparam int EW = 3 * WORD_W;
    localparam int BW = 3 * AW;
    localparam logic signed [TW-1:0] HALF = TW'(64'sd1 <<< (FRAC_BITS - 1));
    localparam logic signed [TW-1:0] WMAX = TW'(64'sd2147483647);
    localparam logic signed [TW-1:0] WMIN = TW'(-64'sd2147483648);
    localparam logic signed [AXIS_W-1:0] AXIS_LIM =
        (FRAC_BITS > 16) ? AXIS_W'(AXIS_MAX) : AXIS_W'(64'sd1 <<< FRAC_BITS);

    function automatic logic signed [AXIS_W-1:0] axis_fit(input logic signed [AW-1:0] v);
        logic signed [WORD_W-1:0] w;
        w = WORD_W'(v);
        if (w > AXIS_MAX)
        begin
            w = AXIS_MAX;
        end
        if (w < AXIS_MIN)
        begin
            w = AXIS_MIN;
        end
        return w[AXIS_W-1:0];
    endfunction

    // input stage
    logic                     in_valid_reg;
    logic signed [VEC_W-1:0]  d_reg [3];
    logic [2:0][WORD_W-1:0]   eye_reg, up_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= start;
        end
    end

    always_ff @(posedge clk)
    begin
        d_reg[0] <= VEC_W'(eye_x) - VEC_W'(target_x);
        d_reg[1] <= VEC_W'(eye_y) - VEC_W'(target_y);
        d_reg[2] <= VEC_W'(eye_z) - VEC_W'(target_z);
        eye_reg  <= {eye_z, eye_y, eye_x};
        up_reg   <= {up_z, up_y, up_x};
    end

    // back axis
    logic                   u1_valid;
    logic signed [AW-1:0]   u1_vec [3];
    logic [2*EW-1:0]        u1_side;
    logic [2:0][WORD_W-1:0] eye1, up1;

    lav_unit #(.FRAC_BITS(FRAC_BITS), .SW(2 * EW)) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid_reg),
        .in_vec   (d_reg),
        .in_side  ({up_reg, eye_reg}),
        .out_valid(u1_valid),
        .out_vec  (u1_vec),
        .out_side (u1_side)
    );

    assign eye1 = u1_side[EW-1:0];
    assign up1  = u1_side[2*EW-1:EW];

    // up cross back
    logic                   c1v_reg [2];
    logic signed [PW-1:0]   c1p_reg [6];
    logic [2:0][WORD_W-1:0] c1e_reg [2];
    logic [2:0][AW-1:0]     c1b_reg [2];
    logic signed [VEC_W-1:0] c1o_reg [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c1v_reg[0] <= 1'b0;
            c1v_reg[1] <= 1'b0;
        end
        else
        begin
            c1v_reg[0] <= u1_valid;
            c1v_reg[1] <= c1v_reg[0];
        end
    end

    always_ff @(posedge clk)
    begin
        c1p_reg[0] <= PW'($signed(up1[1])) * PW'(u1_vec[2]);
        c1p_reg[1] <= PW'($signed(up1[2])) * PW'(u1_vec[1]);
        c1p_reg[2] <= PW'($signed(up1[2])) * PW'(u1_vec[0]);
        c1p_reg[3] <= PW'($signed(up1[0])) * PW'(u1_vec[2]);
        c1p_reg[4] <= PW'($signed(up1[0])) * PW'(u1_vec[1]);
        c1p_reg[5] <= PW'($signed(up1[1])) * PW'(u1_vec[0]);
        c1e_reg[0] <= eye1;
        c1b_reg[0] <= {u1_vec[2], u1_vec[1], u1_vec[0]};
        for (int i = 0; i < 3; i++)
        begin
            c1o_reg[i] <= VEC_W'(c1p_reg[2*i]) - VEC_W'(c1p_reg[2*i+1]);
        end
        c1e_reg[1] <= c1e_reg[0];
        c1b_reg[1] <= c1b_reg[0];
    end

    // side axis
    logic                   u2_valid;
    logic signed [AW-1:0]   u2_vec [3];
    logic [BW+EW-1:0]       u2_side;
    logic [2:0][WORD_W-1:0] eye2;
    logic [2:0][AW-1:0]     back2;

    lav_unit #(.FRAC_BITS(FRAC_BITS), .SW(BW + EW)) u_side (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (c1v_reg[1]),
        .in_vec   (c1o_reg),
        .in_side  ({c1b_reg[1], c1e_reg[1]}),
        .out_valid(u2_valid),
        .out_vec  (u2_vec),
        .out_side (u2_side)
    );

    assign eye2  = u2_side[EW-1:0];
    assign back2 = u2_side[BW+EW-1:EW];

    // back cross side
    logic                   c2v_reg [2];
    logic signed [PW-1:0]   c2p_reg [6];
    logic [2:0][WORD_W-1:0] c2e_reg [2];
    logic [2:0][AW-1:0]     c2b_reg [2];
    logic [2:0][AW-1:0]     c2s_reg [2];
    logic signed [VEC_W-1:0] c2o_reg [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c2v_reg[0] <= 1'b0;
            c2v_reg[1] <= 1'b0;
        end
        else
        begin
            c2v_reg[0] <= u2_valid;
            c2v_reg[1] <= c2v_reg[0];
        end
    end

    always_ff @(posedge clk)
    begin
        c2p_reg[0] <= PW'($signed(back2[1])) * PW'(u2_vec[2]);
        c2p_reg[1] <= PW'($signed(back2[2])) * PW'(u2_vec[1]);
        c2p_reg[2] <= PW'($signed(back2[2])) * PW'(u2_vec[0]);
        c2p_reg[3] <= PW'($signed(back2[0])) * PW'(u2_vec[2]);
        c2p_reg[4] <= PW'($signed(back2[0])) * PW'(u2_vec[1]);
        c2p_reg[5] <= PW'($signed(back2[1])) * PW'(u2_vec[0]);
        c2e_reg[0] <= eye2;
        c2b_reg[0] <= back2;
        c2s_reg[0] <= {u2_vec[2], u2_vec[1], u2_vec[0]};
        for (int i = 0; i < 3; i++)
        begin
            c2o_reg[i] <= VEC_W'(c2p_reg[2*i]) - VEC_W'(c2p_reg[2*i+1]);
        end
        c2e_reg[1] <= c2e_reg[0];
        c2b_reg[1] <= c2b_reg[0];
        c2s_reg[1] <= c2s_reg[0];
    end

    // upright axis
    logic                   u3_valid;
    logic signed [AW-1:0]   u3_vec [3];
    logic [2*BW+EW-1:0]     u3_side;
    logic [2:0][WORD_W-1:0] eye3;
    logic [2:0][AW-1:0]     back3, side3;

    lav_unit #(.FRAC_BITS(FRAC_BITS), .SW(2 * BW + EW)) u_upright (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (c2v_reg[1]),
        .in_vec   (c2o_reg),
        .in_side  ({c2s_reg[1], c2b_reg[1], c2e_reg[1]}),
        .out_valid(u3_valid),
        .out_vec  (u3_vec),
        .out_side (u3_side)
    );

    assign eye3  = u3_side[EW-1:0];
    assign back3 = u3_side[BW+EW-1:EW];
    assign side3 = u3_side[2*BW+EW-1:BW+EW];

    // translation: rows are side, upright, back
    logic                 tv_reg [2];
    logic signed [PW-1:0] tp_reg [3][3];
    logic [2:0][AW-1:0]   ta_reg [2][3];
    logic signed [TW-1:0] tr_reg [3];
    logic [2:0][AW-1:0]   rows [3];
    logic signed [TW-1:0] tsum [3];
    logic signed [TW-1:0] tneg [3];
    logic                 done_reg;

    assign rows[0] = side3;
    assign rows[1] = {u3_vec[2], u3_vec[1], u3_vec[0]};
    assign rows[2] = back3;

    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            tsum[r] = TW'(tp_reg[r][0]) + TW'(tp_reg[r][1]) + TW'(tp_reg[r][2]);
            tneg[r] = -tsum[r] + HALF;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tv_reg[0] <= 1'b0;
            tv_reg[1] <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            tv_reg[0] <= u3_valid;
            tv_reg[1] <= tv_reg[0];
            done_reg  <= tv_reg[1];
        end
    end

    always_ff @(posedge clk)
    begin
        for (int r = 0; r < 3; r++)
        begin
            for (int i = 0; i < 3; i++)
            begin
                tp_reg[r][i] <= PW'($signed(rows[r][i])) * PW'($signed(eye3[i]));
            end
            ta_reg[0][r] <= rows[r];
            tr_reg[r]    <= tneg[r] >>> FRAC_BITS;
            ta_reg[1][r] <= ta_reg[0][r];
        end
    end

    always_ff @(posedge clk)
    begin
        side_x    <= axis_fit($signed(ta_reg[1][0][0]));
        side_y    <= axis_fit($signed(ta_reg[1][0][1]));
        side_z    <= axis_fit($signed(ta_reg[1][0][2]));
        upright_x <= axis_fit($signed(ta_reg[1][1][0]));
        upright_y <= axis_fit($signed(ta_reg[1][1][1]));
        upright_z <= axis_fit($signed(ta_reg[1][1][2]));
        back_x    <= axis_fit($signed(ta_reg[1][2][0]));
        back_y    <= axis_fit($signed(ta_reg[1][2][1]));
        back_z    <= axis_fit($signed(ta_reg[1][2][2]));
        shift_x   <= (tr_reg[0] > WMAX) ? WORD_W'(WMAX) :
                     (tr_reg[0] < WMIN) ? WORD_W'(WMIN) : WORD_W'(tr_reg[0]);
        shift_y   <= (tr_reg[1] > WMAX) ? WORD_W'(WMAX) :
                     (tr_reg[1] < WMIN) ? WORD_W'(WMIN) : WORD_W'(tr_reg[1]);
        shift_z   <= (tr_reg[2] > WMAX) ? WORD_W'(WMAX) :
                     (tr_reg[2] < WMIN) ? WORD_W'(WMIN) : WORD_W'(tr_reg[2]);
    end

    assign done = done_reg;
    assign busy = 1'b0;

    `LAV_ASSERT_IMP(a_back_range, done,
        back_x <= AXIS_LIM && back_x >= -AXIS_LIM && back_y <= AXIS_LIM &&
        back_y >= -AXIS_LIM && back_z <= AXIS_LIM && back_z >= -AXIS_LIM)
    `LAV_ASSERT_IMP(a_zero_back, done && back_x == '0 && back_y == '0 && back_z == '0,
        side_x == '0 && side_y == '0 && side_z == '0 &&
        upright_x == '0 && upright_y == '0 && upright_z == '0)
    `LAV_ASSERT_ALWAYS(a_cross_delay, c1v_reg[1] == $past(u1_valid, 2))
endmodule

[rtl/core/lav_unit.sv]
// Pipelined vector normalizer: scale, sum of squares, root, three dividers.
module lav_unit #(
    parameter int FRAC_BITS = lav_pkg::FRAC_BITS_DEF,
    parameter int SW = 1
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    input  logic signed [lav_pkg::VEC_W-1:0] in_vec [3],
    input  logic [SW-1:0]                   in_side,
    output logic                            out_valid,
    output logic signed [FRAC_BITS+1:0]     out_vec [3],
    output logic [SW-1:0]                   out_side
);
    import lav_pkg::*;

    localparam int AW     = FRAC_BITS + 2;
    localparam int QW     = FRAC_BITS + 1;
    localparam int NSTEP  = 6;
    localparam int REM_W  = ROOT_W + 2;
    localparam int RS_W   = REM_W + 2;
    localparam int NW     = MAG_W + FRAC_BITS + 1;
    localparam logic [QW-1:0] ONE_Q = QW'(1) << FRAC_BITS;

    typedef struct packed {
        logic [2:0]    neg;
        logic          zero;
        logic [SW-1:0] side;
    } tag_t;

    // stage A: magnitudes
    logic             va_reg;
    logic [VEC_W-1:0] ma_reg [3];
    tag_t             ta_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
        end
        else
        begin
            va_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            ma_reg[i]     <= in_vec[i][VEC_W-1] ? $unsigned(-in_vec[i]) : $unsigned(in_vec[i]);
            ta_reg.neg[i] <= in_vec[i][VEC_W-1];
        end
        ta_reg.zero <= 1'b0;
        ta_reg.side <= in_side;
    end

    // stage B and left normalization: largest magnitude to the top bit
    logic             nv_reg [NSTEP+1];
    logic [VEC_W-1:0] nm_reg [NSTEP+1][3];
    logic [VEC_W-1:0] nx_reg [NSTEP+1];
    tag_t             nt_reg [NSTEP+1];
    logic [VEC_W-1:0] max_ab, max_all;

    always_comb
    begin
        max_ab  = (ma_reg[0] > ma_reg[1]) ? ma_reg[0] : ma_reg[1];
        max_all = (max_ab > ma_reg[2]) ? max_ab : ma_reg[2];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nv_reg[0] <= 1'b0;
        end
        else
        begin
            nv_reg[0] <= va_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        nm_reg[0]         <= ma_reg;
        nx_reg[0]         <= max_all;
        nt_reg[0].neg     <= ta_reg.neg;
        nt_reg[0].zero    <= (max_all == '0);
        nt_reg[0].side    <= ta_reg.side;
    end

    for (genvar k = 0; k < NSTEP; k++)
    begin : g_norm
        localparam int SH = 32 >> k;
        logic go;
        assign go = (nx_reg[k][VEC_W-1 -: SH] == '0);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                nv_reg[k+1] <= 1'b0;
            end
            else
            begin
                nv_reg[k+1] <= nv_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            for (int i = 0; i < 3; i++)
            begin
                nm_reg[k+1][i] <= go ? (nm_reg[k][i] << SH) : nm_reg[k][i];
            end
            nx_reg[k+1] <= go ? (nx_reg[k] << SH) : nx_reg[k];
            nt_reg[k+1] <= nt_reg[k];
        end
    end

    // squares
    logic                 qv_reg;
    logic [MAG_W-1:0]     qa_reg [3];
    logic [2*MAG_W-1:0]   qs_reg [3];
    tag_t                 qt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            qv_reg <= 1'b0;
        end
        else
        begin
            qv_reg <= nv_reg[NSTEP];
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            qa_reg[i] <= nm_reg[NSTEP][i][VEC_W-1 -: MAG_W];
            qs_reg[i] <= nm_reg[NSTEP][i][VEC_W-1 -: MAG_W] * nm_reg[NSTEP][i][VEC_W-1 -: MAG_W];
        end
        qt_reg <= nt_reg[NSTEP];
    end

    // square root, one result bit per stage
    logic              sv_reg    [ROOT_W+1];
    logic [SUM_W-1:0]  sn_reg    [ROOT_W+1];
    logic [REM_W-1:0]  srem_reg  [ROOT_W+1];
    logic [ROOT_W-1:0] sroot_reg [ROOT_W+1];
    logic [MAG_W-1:0]  sa_reg    [ROOT_W+1][3];
    tag_t              st_reg    [ROOT_W+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sv_reg[0] <= 1'b0;
        end
        else
        begin
            sv_reg[0] <= qv_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        sn_reg[0]    <= SUM_W'(qs_reg[0]) + SUM_W'(qs_reg[1]) + SUM_W'(qs_reg[2]);
        srem_reg[0]  <= '0;
        sroot_reg[0] <= '0;
        sa_reg[0]    <= qa_reg;
        st_reg[0]    <= qt_reg;
    end

    for (genvar j = 0; j < ROOT_W; j++)
    begin : g_sqrt
        logic [RS_W-1:0] rs, trial;
        logic            ge;

        always_comb
        begin
            rs    = {srem_reg[j], sn_reg[j][SUM_W-1-2*j -: 2]};
            trial = {2'b00, sroot_reg[j], 2'b01};
            ge    = (rs >= trial);
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                sv_reg[j+1] <= 1'b0;
            end
            else
            begin
                sv_reg[j+1] <= sv_reg[j];
            end
        end

        always_ff @(posedge clk)
        begin
            srem_reg[j+1]  <= ge ? REM_W'(rs - trial) : REM_W'(rs);
            sroot_reg[j+1] <= {sroot_reg[j][ROOT_W-2:0], ge};
            sn_reg[j+1]    <= sn_reg[j];
            sa_reg[j+1]    <= sa_reg[j];
            st_reg[j+1]    <= st_reg[j];
        end
    end

    // rounded division, one quotient bit per stage, three lanes
    logic              dv_reg   [QW+1];
    logic [ROOT_W-1:0] dr_reg   [QW+1];
    logic [ROOT_W-1:0] drem_reg [QW+1][3];
    logic [QW-1:0]     dlow_reg [QW+1][3];
    logic [QW-1:0]     dq_reg   [QW+1][3];
    tag_t              dt_reg   [QW+1];
    logic [NW-1:0]     num [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            num[i] = NW'({sa_reg[ROOT_W][i], {FRAC_BITS{1'b0}}})
                   + NW'(sroot_reg[ROOT_W] >> 1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dv_reg[0] <= 1'b0;
        end
        else
        begin
            dv_reg[0] <= sv_reg[ROOT_W];
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            drem_reg[0][i] <= ROOT_W'(num[i][NW-1:QW]);
            dlow_reg[0][i] <= num[i][QW-1:0];
            dq_reg[0][i]   <= '0;
        end
        dr_reg[0] <= sroot_reg[ROOT_W];
        dt_reg[0] <= st_reg[ROOT_W];
    end

    for (genvar d = 0; d < QW; d++)
    begin : g_div
        logic [ROOT_W:0] rs [3];
        logic [2:0]      ge;

        always_comb
        begin
            for (int i = 0; i < 3; i++)
            begin
                rs[i] = {drem_reg[d][i], dlow_reg[d][i][QW-1-d]};
                ge[i] = (rs[i] >= {1'b0, dr_reg[d]});
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dv_reg[d+1] <= 1'b0;
            end
            else
            begin
                dv_reg[d+1] <= dv_reg[d];
            end
        end

        always_ff @(posedge clk)
        begin
            for (int i = 0; i < 3; i++)
            begin
                drem_reg[d+1][i] <= ge[i] ? ROOT_W'(rs[i] - {1'b0, dr_reg[d]})
                                          : ROOT_W'(rs[i]);
                dq_reg[d+1][i]   <= {dq_reg[d][i][QW-2:0], ge[i]};
                dlow_reg[d+1][i] <= dlow_reg[d][i];
            end
            dr_reg[d+1] <= dr_reg[d];
            dt_reg[d+1] <= dt_reg[d];
        end
    end

    // clamp, sign, zero vector
    logic          ov_reg;
    logic [QW-1:0] qc [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            qc[i] = (dq_reg[QW][i] > ONE_Q) ? ONE_Q : dq_reg[QW][i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ov_reg <= 1'b0;
        end
        else
        begin
            ov_reg <= dv_reg[QW];
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (dt_reg[QW].zero)
            begin
                out_vec[i] <= '0;
            end
            else if (dt_reg[QW].neg[i])
            begin
                out_vec[i] <= -$signed(AW'(qc[i]));
            end
            else
            begin
                out_vec[i] <= $signed(AW'(qc[i]));
            end
        end
        out_side <= dt_reg[QW].side;
    end

    assign out_valid = ov_reg;
endmodule

[dv/look_at_view_matrix_top_tb.sv]
// Self-checking testbench for the look-at view matrix block.
`timescale 1ns / 100ps

module look_at_view_matrix_top_tb;

    localparam int FB = lav_pkg::FRAC_BITS_DEF;
    localparam int LATENCY = 3 * FB + 140;
    localparam longint CYCLE_LIMIT = 400000;

    typedef struct {
        logic signed [17:0] ax[9];
        logic signed [31:0] sh[3];
    } view_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy, done;
    logic signed [31:0] eye_x = '0, eye_y = '0, eye_z = '0;
    logic signed [31:0] target_x = '0, target_y = '0, target_z = '0;
    logic signed [31:0] up_x = '0, up_y = '0, up_z = '0;
    logic signed [17:0] side_x, side_y, side_z, upright_x, upright_y, upright_z;
    logic signed [17:0] back_x, back_y, back_z;
    logic signed [31:0] shift_x, shift_y, shift_z;

    view_t expected_views[$];
    int errors = 0;
    longint cycles = 0;

    string ax_name[9] = '{"side_x", "side_y", "side_z", "upright_x", "upright_y",
                          "upright_z", "back_x", "back_y", "back_z"};
    string sh_name[3] = '{"shift_x", "shift_y", "shift_z"};

    look_at_view_matrix_top dut (.*);

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Normalize: scale max magnitude into [2^29,2^30), divide by floor sqrt.
    function automatic void unit_vec(input longint v[3], output longint u[3]);
        logic [63:0] a[3];
        logic [63:0] m, sum, r, rem, bit_v, q;
        bit neg[3];
        m = 0;
        for (int i = 0; i < 3; i++)
        begin
            neg[i] = v[i] < 0;
            a[i] = neg[i] ? -v[i] : v[i];
            if (a[i] > m) m = a[i];
        end
        if (m == 0)
        begin
            u = '{0, 0, 0};
            return;
        end
        while (m >= 64'd1 << 30)
        begin
            m >>= 1;
            for (int i = 0; i < 3; i++) a[i] >>= 1;
        end
        while (m < 64'd1 << 29)
        begin
            m <<= 1;
            for (int i = 0; i < 3; i++) a[i] <<= 1;
        end
        sum = a[0] * a[0] + a[1] * a[1] + a[2] * a[2];
        rem = sum;
        r = 0;
        bit_v = 64'd1 << 62;
        while (bit_v > rem) bit_v >>= 2;
        while (bit_v != 0)
        begin
            if (rem >= r + bit_v)
            begin
                rem -= r + bit_v;
                r = (r >> 1) + bit_v;
            end
            else
                r >>= 1;
            bit_v >>= 2;
        end
        for (int i = 0; i < 3; i++)
        begin
            q = (a[i] * (64'd1 << FB) + (r >> 1)) / r;
            if (q > (64'd1 << FB)) q = 64'd1 << FB;
            u[i] = neg[i] ? -longint'(q) : longint'(q);
        end
    endfunction

    function automatic void cross_vec(input longint p[3], input longint q[3],
                                      output longint o[3]);
        o[0] = p[1] * q[2] - p[2] * q[1];
        o[1] = p[2] * q[0] - p[0] * q[2];
        o[2] = p[0] * q[1] - p[1] * q[0];
    endfunction

    function automatic logic signed [31:0] translate(input longint row[3],
                                                     input longint e[3]);
        longint t, res;
        logic [63:0] b;
        t = -(row[0] * e[0] + row[1] * e[1] + row[2] * e[2]);
        b = 64'(t + (longint'(1) << (FB - 1))) + (64'd1 << 62);
        res = longint'(b >> FB) - longint'(64'd1 << (62 - FB));
        if (res > 64'sd2147483647) res = 64'sd2147483647;
        if (res < -64'sd2147483648) res = -64'sd2147483648;
        return res[31:0];
    endfunction

    function automatic logic signed [17:0] clamp_axis(input longint v);
        if (v > 131071) v = 131071;
        if (v < -131071) v = -131071;
        return v[17:0];
    endfunction

    function automatic view_t predict_view(input logic signed [31:0] in[9]);
        longint e[3], d[3], u[3], bk[3], sd[3], ur[3], tmp[3];
        view_t r;
        for (int i = 0; i < 3; i++)
        begin
            e[i] = in[i];
            d[i] = longint'(in[i]) - longint'(in[3 + i]);
            u[i] = in[6 + i];
        end
        unit_vec(d, bk);
        cross_vec(u, bk, tmp);
        unit_vec(tmp, sd);
        cross_vec(bk, sd, tmp);
        unit_vec(tmp, ur);
        for (int i = 0; i < 3; i++)
        begin
            r.ax[i] = clamp_axis(sd[i]);
            r.ax[3 + i] = clamp_axis(ur[i]);
            r.ax[6 + i] = clamp_axis(bk[i]);
        end
        r.sh[0] = translate(sd, e);
        r.sh[1] = translate(ur, e);
        r.sh[2] = translate(bk, e);
        return r;
    endfunction

    int burst_left = 0;

    // start stays high within a burst; it drops only for a gap or a drain
    task automatic send_item(input logic signed [31:0] in[9]);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 30);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
            if (gap != 0)
            begin
                start <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        eye_x = in[0]; eye_y = in[1]; eye_z = in[2];
        target_x = in[3]; target_y = in[4]; target_z = in[5];
        up_x = in[6]; up_y = in[7]; up_z = in[8];
        start <= 1'b1;
        @(posedge clk);
        while (busy) @(posedge clk);
        expected_views.insert(expected_views.size(), predict_view(in));
        @(negedge clk);
    endtask

    always @(posedge clk)
    begin
        view_t got, exp_v;
        if (rst_n && done)
        begin
            got.ax = '{side_x, side_y, side_z, upright_x, upright_y, upright_z,
                       back_x, back_y, back_z};
            got.sh = '{shift_x, shift_y, shift_z};
            if (expected_views.size() == 0)
            begin
                $error("unexpected result");
                errors++;
            end
            else
            begin
                exp_v = expected_views.pop_front();
                for (int i = 0; i < 9; i++)
                    if (got.ax[i] !== exp_v.ax[i])
                    begin
                        $error("%s expected %0d actual %0d", ax_name[i], exp_v.ax[i],
                               got.ax[i]);
                        errors++;
                    end
                for (int i = 0; i < 3; i++)
                    if (got.sh[i] !== exp_v.sh[i])
                    begin
                        $error("%s expected %0d actual %0d", sh_name[i], exp_v.sh[i],
                               got.sh[i]);
                        errors++;
                    end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    function automatic logic signed [31:0] rand_word();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return $urandom_range(0, 1) ? 32'sh7FFFFFFF : 32'sh80000000;
            2: return $signed($urandom_range(0, 2 * 65536 * 8)) - 65536 * 8;
            3: return $signed($urandom_range(0, 2000)) - 1000;
            default: return $signed($urandom_range(0, 2 * 65536 * 200)) - 65536 * 200;
        endcase
    endfunction

    task automatic send_vecs(input logic signed [31:0] e[3], input logic signed [31:0] t[3],
                             input logic signed [31:0] u[3]);
        logic signed [31:0] in[9];
        in = '{e[0], e[1], e[2], t[0], t[1], t[2], u[0], u[1], u[2]};
        send_item(in);
    endtask

    task automatic test_directed();
        localparam logic signed [31:0] ONE = 32'sd65536;
        localparam logic signed [31:0] MX = 32'sh7FFFFFFF;
        localparam logic signed [31:0] MN = 32'sh80000000;
        send_vecs('{0, 0, 5 * ONE}, '{0, 0, 0}, '{0, ONE, 0});
        send_vecs('{ONE, 2 * ONE, 3 * ONE}, '{ONE, 2 * ONE, 3 * ONE}, '{0, ONE, 0});
        send_vecs('{0, 0, ONE}, '{0, 0, 0}, '{0, 0, 0});
        send_vecs('{0, 0, ONE}, '{0, 0, 0}, '{0, 0, 7 * ONE});
        send_vecs('{0, 0, ONE}, '{0, 0, 0}, '{0, 0, -ONE});
        send_vecs('{MX, MX, MX}, '{MN, MN, MN}, '{MX, MN, MX});
        send_vecs('{MN, MN, MN}, '{MX, MX, MX}, '{MN, MX, MN});
        send_vecs('{MX, MN, MX}, '{0, 0, 0}, '{0, ONE, 0});
        send_vecs('{MN, MN, MN}, '{MN, MN, MN}, '{MN, MN, MN});
        send_vecs('{1, 0, 0}, '{0, 0, 0}, '{0, 1, 0});
        send_vecs('{-1, -1, -1}, '{0, 0, 0}, '{-1, 1, -1});
        send_vecs('{MX, MX, MX}, '{MX - 1, MX, MX}, '{0, 0, 1});
        send_vecs('{3 * ONE, -2 * ONE, ONE}, '{0, 0, 0}, '{0, ONE, 0});
        send_vecs('{32'sh55555555, 32'shAAAAAAAA, 32'sh0F0F0F0F},
                  '{32'shAAAAAAAA, 32'sh55555555, 32'shF0F0F0F0}, '{MX, MX, MN});
    endtask

    task automatic test_drain_pause();
        start <= 1'b0;
        burst_left = 0;
        while (expected_views.size() != 0) @(negedge clk);
    endtask

    task automatic test_random(input int n);
        logic signed [31:0] e[3], t[3], u[3];
        int k;
        for (int i = 0; i < n; i++)
        begin
            foreach (e[j]) e[j] = rand_word();
            foreach (t[j]) t[j] = rand_word();
            foreach (u[j]) u[j] = rand_word();
            k = $urandom_range(0, 19);
            if (k == 0) t = e;
            else if (k == 1) u = '{0, 0, 0};
            else if (k == 2) foreach (u[j]) u[j] = e[j] - t[j];
            else if (k == 3) foreach (u[j]) u[j] = -(e[j] - t[j]) * 3;
            send_vecs(e, t, u);
        end
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        test_directed();
        test_drain_pause();
        test_random(800);
        test_drain_pause();
        test_random(850);
        test_drain_pause();
        repeat (LATENCY + 20) @(posedge clk);
        if (errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

[look_at_view_matrix_top.f]
+incdir+rtl/core
rtl/core/lav_pkg.sv
rtl/core/lav_unit.sv
rtl/core/look_at_view_matrix_top.sv
dv/look_at_view_matrix_top_tb.sv
